// File: rtl/core/pairwise_js_divergence_macros.svh
// assertion helpers for the divergence block
`ifndef PAIRWISE_JS_DIVERGENCE_MACROS_SVH
`define PAIRWISE_JS_DIVERGENCE_MACROS_SVH
// implication checked every clock, masked during reset
`define PJSD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pjsd assertion failed");
// next-cycle implication, masked during reset
`define PJSD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pjsd assertion failed");
`endif

// File: rtl/core/pjsd_pkg.sv
package pjsd_pkg;
  localparam int ROWS = 256;
  localparam int COLS = 64;
  localparam int ROW_W = $clog2(ROWS);
  localparam int COL_W = $clog2(COLS);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int CFG_W = 9;
  localparam int VAL_W = 32;
  localparam int OUT_W = 48;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic signed [31:0] LN2_Q24 = 32'sd11629080;
  localparam logic [OUT_W-1:0] SAT48 = {OUT_W{1'b1}};
  localparam logic [CFG_W-1:0] ROWS_RESET = 9'd256;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_CHECK,
    ST_LOG_S,
    ST_LOG_A,
    ST_LOG_B,
    ST_MUL_A,
    ST_MUL_B,
    ST_ACC,
    ST_OUT
  } state_t;

  // sequencer of the shared log unit
  typedef enum logic [1:0] {
    LG_IDLE,
    LG_NORM,
    LG_SQ,
    LG_LN
  } lg_state_t;

  // request to and reply from the shared log unit
  typedef struct packed {
    logic        start;
    logic [32:0] x;
  } log_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] ln;
  } log_rsp_t;
endpackage

// File: rtl/core/pjsd_in_if.sv
interface pjsd_in_if;
  import pjsd_pkg::*;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [7:0]        row;
  logic [5:0]        col_a;
  logic [5:0]        col_b;
  logic [VAL_W-1:0]  value;
  modport source (output valid, opcode, row, col_a, col_b, value, input ready);
  modport sink (input valid, opcode, row, col_a, col_b, value, output ready);
endinterface

// File: rtl/core/pjsd_out_if.sv
interface pjsd_out_if;
  import pjsd_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] divergence;
  modport source (output valid, divergence, input ready);
  modport sink (input valid, divergence, output ready);
endinterface

// File: rtl/core/pjsd_ram.sv
module pjsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/pjsd_log.sv
module pjsd_log (
  input  logic               clk,
  input  logic               rst_n,
  input  pjsd_pkg::log_req_t req,
  output pjsd_pkg::log_rsp_t rsp
);
  import pjsd_pkg::*;

  lg_state_t   st_r, st_nxt;
  logic [32:0] x_r;
  logic [5:0]  e_r;
  logic [31:0] m_r;
  logic [23:0] f_r;
  logic [4:0]  cnt_r;
  logic [63:0] sq;
  logic [33:0] sq_sh;
  logic [5:0]  top;
  logic [61:0] ln_prod;

  // top set bit of the operand
  always_comb begin
    top = 6'd0;
    for (int i = 0; i < 33; i++) begin
      if (x_r[i]) begin
        top = 6'(i);
      end
    end
  end

  assign sq      = 64'(m_r) * 64'(m_r);
  assign sq_sh   = sq[63:30];
  assign ln_prod = 62'({e_r, f_r}) * 62'(LN2_Q32) + 62'(64'd1 << 31);

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      LG_IDLE: if (req.start) st_nxt = LG_NORM;
      LG_NORM: st_nxt = LG_SQ;
      LG_SQ:   if (cnt_r == 5'd23) st_nxt = LG_LN;
      LG_LN:   st_nxt = LG_IDLE;
      default: st_nxt = LG_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rsp.done = (st_r == LG_LN);
    rsp.ln   = 32'(ln_prod >> 32);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= LG_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // datapath: normalize, then one squaring per cycle
  always_ff @(posedge clk) begin
    unique case (st_r)
      LG_IDLE: begin
        x_r   <= req.x;
        cnt_r <= 5'd0;
        f_r   <= 24'd0;
      end
      LG_NORM: begin
        e_r <= top;
        if (top >= 6'd30) begin
          m_r <= 32'(x_r >> (top - 6'd30));
        end else begin
          m_r <= 32'(x_r << (6'd30 - top));
        end
      end
      LG_SQ: begin
        cnt_r <= cnt_r + 5'd1;
        if (sq_sh[31]) begin
          f_r <= {f_r[22:0], 1'b1};
          m_r <= sq_sh[32:1];
        end else begin
          f_r <= {f_r[22:0], 1'b0};
          m_r <= sq_sh[31:0];
        end
      end
      LG_LN: ;
      default: ;
    endcase
  end
endmodule

// File: rtl/core/pairwise_js_divergence.sv
// Pairwise Jensen-Shannon divergence over two columns of a 256 x 64 matrix of
// unsigned Q16.16 values. A load transaction (opcode 0) writes one element and
// returns nothing; the block is ready again on the next cycle. A query
// transaction (opcode 1) walks rows_in_use rows and returns one Q32.16 sum,
// saturating. Each row takes the two element reads and the zero check; when
// neither value is zero it also takes three natural logs through one shared
// iterative log unit (one squaring step per fraction bit), two multiplies and
// the accumulate. A final read state ends the row walk, and the sum then waits
// on out_if.ready. Elements read before being loaded give an undefined result.
// The block accepts nothing while busy.
`include "pairwise_js_divergence_macros.svh"
module pairwise_js_divergence (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [pjsd_pkg::CFG_W-1:0] cfg_wdata,
  pjsd_in_if.sink                    in_if,
  pjsd_out_if.source                 out_if
);
  import pjsd_pkg::*;

  state_t              st_r, st_nxt;
  logic [CFG_W-1:0]    rows_r;
  logic [CFG_W-1:0]    row_r;
  logic [CFG_W-1:0]    lim;
  logic [COL_W-1:0]    ca_r, cb_r;
  logic [VAL_W-1:0]    a_r, b_r, rdata;
  logic signed [31:0]  ls_r, d_r;
  logic signed [71:0]  term_r;
  logic [OUT_W-1:0]    acc_r;
  logic [48:0]         acc_sum;
  logic signed [71:0]  prod;
  logic [47:0]         tq;
  logic                ram_we;
  logic [ADDR_W-1:0]   raddr;
  log_req_t            lreq;
  log_rsp_t            lrsp;
  logic signed [32:0]  diff;

  assign lim = (rows_r > CFG_W'(ROWS)) ? CFG_W'(ROWS) : rows_r;

  assign ram_we = in_if.valid && in_if.ready && (in_if.opcode == OP_LOAD);
  assign raddr  = (st_r == ST_RD_A) ? {row_r[ROW_W-1:0], ca_r} : {row_r[ROW_W-1:0], cb_r};

  pjsd_ram #(.WIDTH(VAL_W), .DEPTH(ROWS * COLS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({in_if.row, in_if.col_a}),
    .wdata (in_if.value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // shared log unit request
  always_comb begin
    lreq.start = (st_r == ST_LOG_S || st_r == ST_LOG_A || st_r == ST_LOG_B);
    unique case (st_r)
      ST_LOG_S: lreq.x = 33'(a_r) + 33'(b_r);
      ST_LOG_A: lreq.x = 33'(a_r);
      default:  lreq.x = 33'(b_r);
    endcase
  end

  pjsd_log u_log (.clk(clk), .rst_n(rst_n), .req(lreq), .rsp(lrsp));

  assign diff = 33'(signed'(lrsp.ln)) - 33'(ls_r) + 33'(LN2_Q24);
  assign prod = (st_r == ST_MUL_A) ? 72'(signed'({1'b0, a_r})) * 72'(d_r)
                                   : 72'(signed'({1'b0, b_r})) * 72'(d_r);
  assign tq = 48'((term_r + 72'sd8388608) >>> 24);
  assign acc_sum = 49'(acc_r) + 49'(tq);

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (in_if.valid && in_if.opcode == OP_QUERY) st_nxt = ST_RD_A;
      ST_RD_A: st_nxt = (row_r >= lim) ? ST_OUT : ST_RD_B;
      ST_RD_B: st_nxt = ST_CHECK;
      ST_CHECK: st_nxt = (a_r == '0 || rdata == '0) ? ST_RD_A : ST_LOG_S;
      ST_LOG_S: if (lrsp.done) st_nxt = ST_LOG_A;
      ST_LOG_A: if (lrsp.done) st_nxt = ST_MUL_A;
      ST_MUL_A: st_nxt = ST_LOG_B;
      ST_LOG_B: if (lrsp.done) st_nxt = ST_MUL_B;
      ST_MUL_B: st_nxt = ST_ACC;
      ST_ACC:  st_nxt = ST_RD_A;
      ST_OUT:  if (out_if.ready) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_if.ready       = (st_r == ST_IDLE);
    out_if.valid      = (st_r == ST_OUT);
    out_if.divergence = acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      rows_r <= ROWS_RESET;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        rows_r <= cfg_wdata;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: begin
        ca_r   <= in_if.col_a;
        cb_r   <= in_if.col_b;
        row_r  <= '0;
        acc_r  <= '0;
      end
      ST_RD_B: a_r <= rdata;
      ST_CHECK: begin
        b_r   <= rdata;
        row_r <= row_r + CFG_W'(1);
      end
      ST_LOG_S: if (lrsp.done) ls_r <= signed'(lrsp.ln);
      ST_LOG_A: if (lrsp.done) d_r <= 32'(diff);
      ST_MUL_A: term_r <= prod;
      ST_LOG_B: if (lrsp.done) d_r <= 32'(diff);
      ST_MUL_B: term_r <= term_r + prod;
      ST_ACC: begin
        if (term_r > 72'sd0) begin
          acc_r <= acc_sum[48] ? SAT48 : acc_sum[47:0];
        end
      end
      default: ;
    endcase
  end

  `PJSD_ASSERT_IMP(a_busy_not_ready, st_r != ST_IDLE, !in_if.ready)
  `PJSD_ASSERT_NXT(a_out_clears, out_if.valid && out_if.ready, st_r == ST_IDLE)
  `PJSD_ASSERT_IMP(a_row_bound, st_r == ST_LOG_S, row_r <= lim)
endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

// mirror of the divergence block plus the queue of sums still owed
class js_scoreboard;
  logic [31:0]  matrix [0:pjsd_pkg::ROWS*pjsd_pkg::COLS-1];
  int unsigned  rows_cfg;
  logic [47:0]  sums_due [$];
  int           errors;

  function new();
    rows_cfg = 32'(pjsd_pkg::ROWS_RESET);
    errors   = 0;
  endfunction

  function void set_rows(int unsigned n);
    rows_cfg = n;
  endfunction

  function int pending();
    return sums_due.size();
  endfunction

  // log2 of a nonzero raw value, Q.24, by repeated squaring
  function longint unsigned log2_q24(longint unsigned x);
    int unsigned     e;
    longint unsigned t;
    longint unsigned m;
    longint unsigned f;
    e = 0;
    t = x;
    f = 0;
    while (t > 1) begin
      t = t >> 1;
      e++;
    end
    if (e >= 30) m = x >> (e - 30);
    else m = x << (30 - e);
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      f = f << 1;
      if (m >= (64'd2 << 30)) begin
        f = f | 1;
        m = m >> 1;
      end
    end
    return (longint'(e) << 24) | f;
  endfunction

  function longint ln_q24(longint unsigned x);
    longint unsigned l2;
    l2 = log2_q24(x);
    return longint'((l2 * 64'(pjsd_pkg::LN2_Q32) + (64'd1 << 31)) >> 32);
  endfunction

  // divergence sum over the first rows of two columns
  function logic [47:0] column_divergence(int unsigned ca, int unsigned cb);
    longint unsigned acc;
    longint unsigned a;
    longint unsigned b;
    longint          ls;
    longint          da;
    longint          db;
    longint          term;
    int unsigned     n;
    acc = 0;
    n = (rows_cfg > pjsd_pkg::ROWS) ? pjsd_pkg::ROWS : rows_cfg;
    for (int unsigned r = 0; r < n; r++) begin
      a = 64'(matrix[r * pjsd_pkg::COLS + ca]);
      b = 64'(matrix[r * pjsd_pkg::COLS + cb]);
      if (a == 0 || b == 0) continue;
      ls = ln_q24(a + b);
      da = ln_q24(a) - ls + 64'(pjsd_pkg::LN2_Q24);
      db = ln_q24(b) - ls + 64'(pjsd_pkg::LN2_Q24);
      term = longint'(a) * da + longint'(b) * db;
      if (term <= 0) continue;
      acc = acc + ((unsigned'(term) + (64'd1 << 23)) >> 24);
      if (acc > 64'(pjsd_pkg::SAT48)) acc = 64'(pjsd_pkg::SAT48);
    end
    return acc[47:0];
  endfunction

  // accepted input transaction
  function void note_input(pjsd_pkg::opcode_t op, logic [7:0] row, logic [5:0] ca,
                           logic [5:0] cb, logic [31:0] val);
    if (op == pjsd_pkg::OP_LOAD) matrix[row * pjsd_pkg::COLS + ca] = val;
    else sums_due.push_back(column_divergence(ca, cb));
  endfunction

  // accepted result transaction
  function void check_result(logic [47:0] got);
    logic [47:0] want;
    if (sums_due.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    want = sums_due.pop_front();
    if (got !== want) begin
      $display("%0t: divergence mismatch, expected %h, actual %h", $time, want, got);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import pjsd_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  bit               written [0:ROWS-1][0:COLS-1];
  bit               burst_in;
  bit               burst_out;
  js_scoreboard     sb;

  pjsd_in_if  in_if ();
  pjsd_out_if out_if ();

  pairwise_js_divergence dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_if),
    .out_if    (out_if)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  // result side: random stalls, check on every accepted transaction
  initial begin
    int stall;
    stall = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        sb.check_result(out_if.divergence);
        if ($urandom_range(0, 15) == 0) burst_out = !burst_out;
        stall = burst_out ? 0 : $urandom_range(0, 5);
      end
      out_if.ready <= (stall == 0);
      if (stall > 0) stall--;
    end
  end

  // one input transaction, with a random gap before it
  task automatic send_item(opcode_t op, logic [7:0] row, logic [5:0] ca, logic [5:0] cb,
                           logic [31:0] val);
    int gap;
    if ($urandom_range(0, 15) == 0) burst_in = !burst_in;
    gap = burst_in ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.opcode <= op;
    in_if.row    <= row;
    in_if.col_a  <= ca;
    in_if.col_b  <= cb;
    in_if.value  <= val;
    in_if.valid  <= 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_input(op, row, ca, cb, val);
  endtask

  task automatic load_elem(int row, int col, logic [31:0] val);
    send_item(OP_LOAD, 8'(row), 6'(col), 6'($urandom), val);
    written[row][col] = 1'b1;
  endtask

  task automatic query_pair(int ca, int cb);
    send_item(OP_QUERY, 8'($urandom), 6'(ca), 6'(cb), $urandom);
  endtask

  // drain all owed sums, then let any load in flight finish
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_rows(int unsigned n);
    cfg_wdata <= CFG_W'(n);
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_rows(n);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom_range(1, 255);
      default: return $urandom;
    endcase
  endfunction

  // a query may only touch rows that have been loaded
  function automatic bit rows_loaded(int ca, int cb, int unsigned n);
    if (n > ROWS) n = ROWS;
    for (int r = 0; r < n; r++)
      if (!written[r][ca] || !written[r][cb]) return 1'b0;
    return 1'b1;
  endfunction

  initial begin
    int ca;
    int cb;
    bit found;
    sb = new();
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_if.valid  <= 1'b0;
    in_if.opcode <= OP_LOAD;
    in_if.row    <= '0;
    in_if.col_a  <= '0;
    in_if.col_b  <= '0;
    in_if.value  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the first 16 rows of four columns, extremes in the first rows
    write_rows(16);
    for (int r = 0; r < 16; r++) begin
      load_elem(r, 0, r == 0 ? 32'hFFFF_FFFF : r == 1 ? 32'd1 : r == 2 ? 32'd0 :
                      r == 3 ? 32'd1 : pick_value());
      load_elem(r, 1, r == 0 ? 32'hFFFF_FFFF : r == 1 ? 32'd1 : r == 3 ? 32'hFFFF_FFFF :
                      pick_value());
      load_elem(r, 62, $urandom);
      load_elem(r, 63, $urandom);
    end
    // loads outside the useful range of other fields
    load_elem(255, 63, 32'hFFFF_FFFF);
    query_pair(0, 1);
    query_pair(1, 0);
    query_pair(0, 0);
    query_pair(62, 63);
    query_pair(63, 1);
    drain();

    // no rows, then a single row
    write_rows(0);
    query_pair(0, 1);
    query_pair(62, 63);
    drain();
    write_rows(1);
    query_pair(0, 1);
    query_pair(63, 62);
    drain();

    // random mix of loads and queries over 16 rows
    write_rows(16);
    for (int i = 0; i < 60; i++) begin
      if ($urandom_range(0, 9) < 6) begin
        load_elem($urandom_range(0, 2) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 15),
                  $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 63),
                  pick_value());
      end else begin
        found = 1'b0;
        for (int t = 0; t < 20 && !found; t++) begin
          ca = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(56, 63);
          cb = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(56, 63);
          found = rows_loaded(ca, cb, 16);
        end
        if (!found) begin
          ca = 0;
          cb = 63;
        end
        query_pair(ca, cb);
      end
    end
    drain();

    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
